// ----- hdl/i2cm_pkg.sv -----
`default_nettype none

package i2cm_pkg;

    // command codes carried in func
    localparam logic [2:0] FUNC_NONE  = 3'd0;
    localparam logic [2:0] FUNC_START = 3'd1;
    localparam logic [2:0] FUNC_STOP  = 3'd2;
    localparam logic [2:0] FUNC_WRITE = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;

    // configuration register indexes
    localparam logic CFG_UNIT_TICKS  = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    localparam logic [15:0] UNIT_TICKS_RESET  = 16'd1;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

    // delay lengths in units
    localparam logic [2:0] UNITS_LONG = 3'd4;
    localparam logic [2:0] UNITS_HALF = 3'd2;
    localparam logic [2:0] UNITS_ONE  = 3'd1;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
        logic       refused;
    } out_item_t;

    // item as classified by the front end
    typedef struct packed {
        logic       cmd;
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } q_item_t;

endpackage

`default_nettype wire

// ----- hdl/i2cm_front.sv -----
`default_nettype none

module i2cm_front #(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  i2cm_pkg::in_item_t  in_data,
    output logic                q_valid,
    output i2cm_pkg::q_item_t   q_item,
    input  wire                 q_pop
);
    import i2cm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    q_item_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    q_item_t          classified;
    logic             push;
    logic             pop;

    // tag real commands so the back end only needs one bit
    always_comb
    begin
        classified.cmd      = in_data.func inside {[FUNC_START:FUNC_READ]};
        classified.func     = in_data.func;
        classified.tx_byte  = in_data.tx_byte;
        classified.send_ack = in_data.send_ack;
        classified.sda_in   = in_data.sda_in;
    end

    assign in_stall = (count_reg == FULL_CNT);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/i2cm_engine.sv -----
`default_nettype none

module i2cm_engine (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  wire                 cfg_index,
    input  wire  [15:0]         cfg_data,
    input  wire                 q_valid,
    input  i2cm_pkg::q_item_t   q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  wire                 out_stall,
    output i2cm_pkg::out_item_t out_data
);
    import i2cm_pkg::*;

    typedef enum logic [14:0] {
        PH_IDLE     = 15'b000000000000001,
        PH_ST_A     = 15'b000000000000010,
        PH_ST_B     = 15'b000000000000100,
        PH_SP_A     = 15'b000000000001000,
        PH_SP_B     = 15'b000000000010000,
        PH_WR_SETUP = 15'b000000000100000,
        PH_WR_HIGH  = 15'b000000001000000,
        PH_WR_LOW   = 15'b000000010000000,
        PH_WA_REL   = 15'b000000100000000,
        PH_WA_HIGH  = 15'b000001000000000,
        PH_WA_POLL  = 15'b000010000000000,
        PH_RD_LOW   = 15'b000100000000000,
        PH_RD_HIGH  = 15'b001000000000000,
        PH_AK_A     = 15'b010000000000000,
        PH_AK_B     = 15'b100000000000000
    } phase_t;

    logic [15:0] unit_ticks_reg;
    logic [7:0]  ack_timeout_reg;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] delay_count_reg, delay_count_next;
    logic [7:0]  poll_count_reg, poll_count_next;
    logic        scl_level_reg, scl_level_next;
    logic        sda_level_reg, sda_level_next;
    logic        ack_choice_reg, ack_choice_next;
    logic        fail_flag_reg, fail_flag_next;
    logic [2:0]  units_left_reg, units_left_next;
    logic [7:0]  rx_hold_reg, rx_hold_next;

    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    logic        step;
    logic        fin;
    logic        refused;
    logic        do_poll;
    logic [7:0]  poll_base;
    logic [15:0] unit;
    logic [15:0] dc_inc;
    logic [2:0]  units_dec;
    logic [3:0]  bi_inc;

    assign step      = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop     = step;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign unit   = (unit_ticks_reg == '0) ? 16'd1 : unit_ticks_reg;
    assign dc_inc = delay_count_reg + 16'd1;
    assign bi_inc = bit_index_reg + 4'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        bit_index_next   = bit_index_reg;
        shift_next       = shift_reg;
        delay_count_next = delay_count_reg;
        poll_count_next  = poll_count_reg;
        scl_level_next   = scl_level_reg;
        sda_level_next   = sda_level_reg;
        ack_choice_next  = ack_choice_reg;
        fail_flag_next   = fail_flag_reg;
        units_left_next  = units_left_reg;
        rx_hold_next     = rx_hold_reg;
        fin              = 1'b0;
        refused          = 1'b0;
        do_poll          = 1'b0;
        poll_base        = poll_count_reg;
        units_dec        = (units_left_reg != '0) ? units_left_reg - 3'd1 : 3'd0;

        if (step)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (q_item.cmd)
                begin
                    fail_flag_next   = 1'b0;
                    delay_count_next = '0;
                    case (q_item.func)
                        FUNC_START:
                        begin
                            scl_level_next  = 1'b1;
                            sda_level_next  = 1'b1;
                            units_left_next = UNITS_LONG;
                            phase_next      = PH_ST_A;
                        end
                        FUNC_STOP:
                        begin
                            scl_level_next  = 1'b0;
                            sda_level_next  = 1'b0;
                            units_left_next = UNITS_LONG;
                            phase_next      = PH_SP_A;
                        end
                        FUNC_WRITE:
                        begin
                            shift_next      = q_item.tx_byte;
                            bit_index_next  = '0;
                            scl_level_next  = 1'b0;
                            sda_level_next  = q_item.tx_byte[7];
                            units_left_next = UNITS_HALF;
                            phase_next      = PH_WR_SETUP;
                        end
                        default:
                        begin
                            ack_choice_next = q_item.send_ack;
                            shift_next      = '0;
                            bit_index_next  = '0;
                            scl_level_next  = 1'b0;
                            sda_level_next  = 1'b1;
                            units_left_next = UNITS_HALF;
                            phase_next      = PH_RD_LOW;
                        end
                    endcase
                end
            end
            else
            begin
                refused = q_item.cmd;
                if (phase_reg == PH_WA_POLL)
                begin
                    do_poll = 1'b1;
                end
                else if (dc_inc >= unit)
                begin
                    delay_count_next = '0;
                    units_left_next  = units_dec;
                    if (units_dec == '0)
                    begin
                        case (phase_reg)
                            PH_ST_A:
                            begin
                                sda_level_next  = 1'b0;
                                units_left_next = UNITS_LONG;
                                phase_next      = PH_ST_B;
                            end
                            PH_ST_B:
                            begin
                                scl_level_next = 1'b0;
                                phase_next     = PH_IDLE;
                                fin            = 1'b1;
                            end
                            PH_SP_A:
                            begin
                                scl_level_next  = 1'b1;
                                sda_level_next  = 1'b1;
                                units_left_next = UNITS_LONG;
                                phase_next      = PH_SP_B;
                            end
                            PH_SP_B:
                            begin
                                phase_next = PH_IDLE;
                                fin        = 1'b1;
                            end
                            PH_WR_SETUP:
                            begin
                                scl_level_next  = 1'b1;
                                units_left_next = UNITS_HALF;
                                phase_next      = PH_WR_HIGH;
                            end
                            PH_WR_HIGH:
                            begin
                                scl_level_next  = 1'b0;
                                units_left_next = UNITS_HALF;
                                phase_next      = PH_WR_LOW;
                            end
                            PH_WR_LOW:
                            begin
                                bit_index_next = bi_inc;
                                if (bi_inc < BITS_PER_BYTE)
                                begin
                                    shift_next      = {shift_reg[6:0], 1'b0};
                                    sda_level_next  = shift_reg[6];
                                    units_left_next = UNITS_HALF;
                                    phase_next      = PH_WR_SETUP;
                                end
                                else
                                begin
                                    // release sda for the slave acknowledge
                                    sda_level_next  = 1'b1;
                                    units_left_next = UNITS_ONE;
                                    phase_next      = PH_WA_REL;
                                end
                            end
                            PH_WA_REL:
                            begin
                                scl_level_next  = 1'b1;
                                units_left_next = UNITS_ONE;
                                phase_next      = PH_WA_HIGH;
                            end
                            PH_WA_HIGH:
                            begin
                                poll_base = '0;
                                do_poll   = 1'b1;
                            end
                            PH_RD_LOW:
                            begin
                                scl_level_next  = 1'b1;
                                shift_next      = {shift_reg[6:0], q_item.sda_in};
                                units_left_next = UNITS_ONE;
                                phase_next      = PH_RD_HIGH;
                            end
                            PH_RD_HIGH:
                            begin
                                bit_index_next = bi_inc;
                                scl_level_next = 1'b0;
                                units_left_next = UNITS_HALF;
                                if (bi_inc < BITS_PER_BYTE)
                                begin
                                    phase_next = PH_RD_LOW;
                                end
                                else
                                begin
                                    rx_hold_next   = shift_reg;
                                    sda_level_next = !ack_choice_reg;
                                    phase_next     = PH_AK_A;
                                end
                            end
                            PH_AK_A:
                            begin
                                scl_level_next  = 1'b1;
                                units_left_next = UNITS_HALF;
                                phase_next      = PH_AK_B;
                            end
                            PH_AK_B:
                            begin
                                scl_level_next = 1'b0;
                                phase_next     = PH_IDLE;
                                fin            = 1'b1;
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
                else
                begin
                    delay_count_next = dc_inc;
                end
            end

            // acknowledge poll, shared by the first sample and the retries
            if (do_poll)
            begin
                poll_count_next = poll_base;
                if (!q_item.sda_in)
                begin
                    scl_level_next = 1'b0;
                    phase_next     = PH_IDLE;
                    fin            = 1'b1;
                end
                else if (poll_base >= ack_timeout_reg)
                begin
                    fail_flag_next   = 1'b1;
                    scl_level_next   = 1'b0;
                    sda_level_next   = 1'b0;
                    delay_count_next = '0;
                    units_left_next  = UNITS_LONG;
                    phase_next       = PH_SP_A;
                end
                else
                begin
                    poll_count_next = poll_base + 8'd1;
                    phase_next      = PH_WA_POLL;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (step)
        begin
            out_valid_next           = 1'b1;
            out_data_next.scl_out    = scl_level_next;
            out_data_next.sda_out    = sda_level_next;
            out_data_next.busy_res   = (phase_next != PH_IDLE);
            out_data_next.done_res   = fin;
            out_data_next.rx_byte    = rx_hold_next;
            out_data_next.ack_failed = fin && fail_flag_next;
            out_data_next.refused    = refused;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg  <= UNIT_TICKS_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
            phase_reg       <= PH_IDLE;
            bit_index_reg   <= '0;
            shift_reg       <= '0;
            delay_count_reg <= '0;
            poll_count_reg  <= '0;
            scl_level_reg   <= 1'b1;
            sda_level_reg   <= 1'b1;
            ack_choice_reg  <= 1'b0;
            fail_flag_reg   <= 1'b0;
            units_left_reg  <= '0;
            rx_hold_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_UNIT_TICKS:  unit_ticks_reg  <= cfg_data;
                    CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data[7:0];
                    default:         unit_ticks_reg  <= unit_ticks_reg;
                endcase
            end
            phase_reg       <= phase_next;
            bit_index_reg   <= bit_index_next;
            shift_reg       <= shift_next;
            delay_count_reg <= delay_count_next;
            poll_count_reg  <= poll_count_next;
            scl_level_reg   <= scl_level_next;
            sda_level_reg   <= sda_level_next;
            ack_choice_reg  <= ack_choice_next;
            fail_flag_reg   <= fail_flag_next;
            units_left_reg  <= units_left_next;
            rx_hold_reg     <= rx_hold_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ----- hdl/i2c_master_byte_engine.sv -----
// an accepted transaction is written into the input queue, and its result into the
// output register when the line engine steps on it; out_stall can delay that step
// throughput: one transaction per cycle, unless out_stall holds the line engine
// reset: asynchronous, active low; scl and sda levels released (out_data not reset), engine idle, queue empty,
// unit_ticks 1 and ack_timeout 250
`default_nettype none

module i2c_master_byte_engine #(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  wire                 cfg_index,
    input  wire  [15:0]         cfg_data,
    input  wire                 in_valid,
    output logic                in_stall,
    input  i2cm_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  wire                 out_stall,
    output i2cm_pkg::out_item_t out_data
);
    import i2cm_pkg::*;

    logic    q_valid;
    logic    q_pop;
    q_item_t q_item;

    i2cm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    i2cm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
